// ===== hw/rtl/ptca_pkg.sv =====
// shared constants, register indexes and control/status types for the core allocator
package ptca_pkg;

  localparam int MAX_TASKS = 16;
  localparam int MAX_CORES = 64;

  localparam int TASK_W  = 4;
  localparam int COUNT_W = 7;
  localparam int CORE_W  = 6;
  localparam int REG_W   = 64;
  localparam int IDX_W   = 2;
  localparam int TILE_W  = 4;
  localparam int LO_W    = TILE_W + COUNT_W;
  localparam int HI_W    = LO_W + 1;

  // popcount is taken a slice at a time
  localparam int SLICE_W  = 8;
  localparam int SLICES   = MAX_CORES / SLICE_W;
  localparam int SLICE_IW = $clog2(SLICES);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CORES_PER_TILE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_TOTAL_CORES     = 2'd1;
  localparam logic [IDX_W-1:0] REG_PREFERRED_TILES = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic build;
    logic count;
    logic emit;
    logic refuse;
  } ptca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_done;
    logic enough;
    logic emit_last;
  } ptca_status_t;

endpackage

// ===== hw/rtl/ptca_ctrl.sv =====
// sequencing state machine for the core allocator
module ptca_ctrl import ptca_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  ptca_status_t st,
  output ptca_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_BUILD  = 6'b000010,
    S_COUNT  = 6'b000100,
    S_CHECK  = 6'b001000,
    S_EMIT   = 6'b010000,
    S_REFUSE = 6'b100000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_BUILD;
        end
      end
      S_BUILD: begin
        cmd.build  = 1'b1;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd.count = 1'b1;
        if (st.count_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = st.enough ? S_EMIT : S_REFUSE;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.emit_last) begin
          state_next = S_IDLE;
        end
      end
      S_REFUSE: begin
        cmd.refuse = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hw/rtl/ptca_dp.sv =====
// config registers, window mask, free-core count and core picker
module ptca_dp import ptca_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_index,
  input  logic [REG_W-1:0]    wr_data,
  input  logic [TASK_W-1:0]   task_id,
  input  logic [COUNT_W-1:0]  core_count,
  input  logic [MAX_CORES-1:0] available_mask,
  input  ptca_cmd_t           cmd,
  output ptca_status_t        st,
  output logic [CORE_W-1:0]   core_index,
  output logic                granted,
  output logic                last,
  output logic                strobe
);

  logic [COUNT_W-1:0]   cores_per_tile;
  logic [COUNT_W-1:0]   total_cores;
  logic [REG_W-1:0]     preferred_tiles;

  logic [COUNT_W-1:0]   want;
  logic                 bad;
  logic [LO_W-1:0]      lo;
  logic [COUNT_W-1:0]   hi;
  logic [MAX_CORES-1:0] avail;
  logic [MAX_CORES-1:0] work;
  logic [COUNT_W-1:0]   cnt;
  logic [COUNT_W-1:0]   sent;
  logic [SLICE_IW-1:0]  slice;

  logic [TILE_W-1:0]    tile;
  logic                 use_tile;
  logic [LO_W-1:0]      lo_calc;
  logic [HI_W-1:0]      hi_sel;
  logic [COUNT_W-1:0]   limit;
  logic [COUNT_W-1:0]   hi_calc;
  logic [MAX_CORES-1:0] window;
  logic [SLICE_W-1:0]   slice_bits;
  logic [COUNT_W-1:0]   pop;
  logic [MAX_CORES-1:0] pick;
  logic [CORE_W-1:0]    pick_idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cores_per_tile  <= 7'd4;
      total_cores     <= 7'd16;
      preferred_tiles <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CORES_PER_TILE:  cores_per_tile  <= wr_data[COUNT_W-1:0];
        REG_TOTAL_CORES:     total_cores     <= wr_data[COUNT_W-1:0];
        REG_PREFERRED_TILES: preferred_tiles <= wr_data;
        default: ;
      endcase
    end
  end

  // window bounds for the incoming task
  always_comb begin
    tile     = preferred_tiles[{task_id, 2'b00} +: TILE_W];
    use_tile = (task_id == '0) || (tile != '0);
    lo_calc  = use_tile ? LO_W'(tile) * LO_W'(cores_per_tile) : LO_W'(cores_per_tile);
    hi_sel   = use_tile ? HI_W'(lo_calc) + HI_W'(cores_per_tile) : HI_W'(total_cores);
    limit    = (total_cores > COUNT_W'(MAX_CORES)) ? COUNT_W'(MAX_CORES) : total_cores;
    hi_calc  = (hi_sel > HI_W'(limit)) ? limit : hi_sel[COUNT_W-1:0];
  end

  // per-core window membership
  always_comb begin
    for (int c = 0; c < MAX_CORES; c++) begin
      window[c] = (LO_W'(c) >= lo) && (COUNT_W'(c) < hi);
    end
  end

  // popcount of the current slice
  always_comb begin
    slice_bits = work[{slice, 3'b000} +: SLICE_W];
    pop        = '0;
    for (int b = 0; b < SLICE_W; b++) begin
      pop = pop + COUNT_W'(slice_bits[b]);
    end
  end

  // lowest free core: isolate the bit, then encode it
  always_comb begin
    pick     = work & (~work + 1'b1);
    pick_idx = '0;
    for (int c = 0; c < MAX_CORES; c++) begin
      if (pick[c]) begin
        pick_idx = pick_idx | CORE_W'(c);
      end
    end
  end

  // status back to the controller
  assign st.count_done = (slice == SLICE_IW'(SLICES - 1));
  assign st.enough     = !bad && (cnt >= want);
  assign st.emit_last  = ((sent + 1'b1) == want);

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      want  <= core_count;
      bad   <= (core_count == '0) || (core_count > COUNT_W'(MAX_CORES));
      lo    <= lo_calc;
      hi    <= hi_calc;
      avail <= available_mask;
    end
    if (cmd.build) begin
      work  <= avail & window;
      cnt   <= '0;
      sent  <= '0;
      slice <= '0;
    end
    if (cmd.count) begin
      cnt   <= cnt + pop;
      slice <= slice + 1'b1;
    end
    if (cmd.emit) begin
      work <= work & ~pick;
      sent <= sent + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit || cmd.refuse;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      core_index <= pick_idx;
      granted    <= 1'b1;
      last       <= st.emit_last;
    end else if (cmd.refuse) begin
      core_index <= '0;
      granted    <= 1'b0;
      last       <= 1'b1;
    end
  end

  // a refusal is always a single closing result at core zero
  a_refuse_form: assert property (@(posedge clk) disable iff (rst)
    strobe && !granted |-> last && (core_index == '0))
    else $error("refusal result malformed");

  // picking only happens while free cores remain in the window
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (work != '0))
    else $error("emit with empty work mask");

  // each pick shows up as a granted result the next cycle
  a_emit_result: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> strobe && granted)
    else $error("emitted core not presented");

  // granted cores come out in ascending order
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    strobe && granted && !last |=> strobe && (core_index > $past(core_index)))
    else $error("granted cores out of order");

endmodule

// ===== hw/rtl/preferred_tile_core_allocator.sv =====
// top level of the preferred-tile core allocator
//
// A request (task_id, core_count, available_mask) is taken at a clock edge
// where start is high and busy is low. The task's preferred tile picks a
// window of cores; the first core_count free cores of that window come out
// in ascending order, one per cycle on core_index with granted=1, the last
// one marked by last. If the window holds too few free cores, or core_count
// is zero or above 64, a single result with granted=0, last=1 comes out.
// Each result is valid for exactly one cycle, marked by strobe; the
// receiver cannot stall, so results are never held back.
// The first result follows these steps in order: bounds, window mask,
// 8 popcount slices of 8 cores, decision, result register. A task other
// than 0 with no preferred tile gets cores from cores_per_tile up to, not
// including, total_cores. busy stays high until the last result is
// registered; a new request may be accepted in that result cycle.
// Configuration: wr_en, wr_index, wr_data write one of cores_per_tile (0),
// total_cores (1) or preferred_tiles (2), by wr_index; write only while idle.
// Synchronous reset returns to idle and loads cores_per_tile=4,
// total_cores=16, preferred_tiles=0; no result is pending after reset.
module preferred_tile_core_allocator import ptca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [TASK_W-1:0]    task_id,
  input  logic [COUNT_W-1:0]   core_count,
  input  logic [MAX_CORES-1:0] available_mask,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_index,
  input  logic [REG_W-1:0]     wr_data,
  output logic                 strobe,
  output logic [CORE_W-1:0]    core_index,
  output logic                 granted,
  output logic                 last
);

  ptca_cmd_t    cmd;
  ptca_status_t st;
  logic         ctrl_busy;

  // controller
  ptca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (ctrl_busy)
  );

  // datapath
  ptca_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .task_id        (task_id),
    .core_count     (core_count),
    .available_mask (available_mask),
    .cmd            (cmd),
    .st             (st),
    .core_index     (core_index),
    .granted        (granted),
    .last           (last),
    .strobe         (strobe)
  );

  assign busy = ctrl_busy;

endmodule
